[sv/smo_pau_pkg.sv]
// Types and constants shared by the SMO pair alpha update pipeline.
`default_nettype none

package smo_pau_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int TAU_W     = 17;
    localparam int NUM_W     = 34;
    localparam int MAG_W     = 33;
    localparam int QUAD_W    = 35;
    localparam int DIV_W     = 33;
    localparam int DVD_W     = MAG_W + FRAC_BITS;
    localparam int DS_W      = 34;
    localparam int AW        = 52;
    localparam int CHG_W     = 33;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C_POSITIVE = 2'd0,
        CFG_C_NEGATIVE = 2'd1,
        CFG_TAU        = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic              opposite;
        logic              flag_a;
        logic              flag_b;
        logic              num_neg;
        logic [DS_W-1:0]   ds;
        logic [DATA_W-1:0] alpha_i_old;
        logic [DATA_W-1:0] alpha_j_old;
        logic [DATA_W-1:0] c_i;
        logic [DATA_W-1:0] c_j;
    } side_t;

    typedef struct packed {
        logic [DIV_W-1:0] divisor;
        logic [DIV_W-1:0] rem;
        logic [DVD_W-1:0] dq;
    } div_t;

endpackage

`default_nettype wire

[sv/smo_pair_alpha_update.sv]
// Pipelined SMO two-variable alpha update with restoring divider.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-----------------------------------------
//  request   | in        | req_valid/req_stall  | labels, gradients, kernel entries, alphas
//  result    | out       | res_valid/res_stall  | new alphas, alpha changes
//  config    | in        | cfg_we               | cfg_index, cfg_data
//
//  One request enters per cycle unless a stalled result freezes the pipeline.
//  The restoring divider has 49 stages, one quotient bit per stage.
//  Reset clears all valid bits and loads the bound and tau registers.
//  A stalled result freezes the whole pipeline; req_stall is raised in that cycle.
`default_nettype none

module smo_pair_alpha_update
    import smo_pau_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    input  wire logic                 req_valid,
    output      logic                 req_stall,
    input  wire logic                 label_i_positive,
    input  wire logic                 label_j_positive,
    input  wire logic [DATA_W-1:0]    grad_i,
    input  wire logic [DATA_W-1:0]    grad_j,
    input  wire logic [DATA_W-1:0]    kern_ii,
    input  wire logic [DATA_W-1:0]    kern_jj,
    input  wire logic [DATA_W-1:0]    kern_ij,
    input  wire logic [DATA_W-1:0]    alpha_i_old,
    input  wire logic [DATA_W-1:0]    alpha_j_old,
    output      logic                 res_valid,
    input  wire logic                 res_stall,
    output      logic [DATA_W-1:0]    alpha_i_new,
    output      logic [DATA_W-1:0]    alpha_j_new,
    output      logic [CHG_W-1:0]     change_i,
    output      logic [CHG_W-1:0]     change_j
);

    localparam int STAGES = DVD_W;
    localparam int OCC_W  = STAGES + 7;

    logic advance;

    logic [DATA_W-1:0] c_positive_reg;
    logic [DATA_W-1:0] c_negative_reg;
    logic [TAU_W-1:0]  tau_reg;

    logic              s1_valid_reg;
    logic              s1_opposite_reg;
    logic [DATA_W-1:0] s1_gi_reg, s1_gj_reg;
    logic [DATA_W-1:0] s1_kii_reg, s1_kjj_reg, s1_kij_reg;
    logic [DATA_W-1:0] s1_ai_reg, s1_aj_reg;
    logic [DATA_W-1:0] s1_ci_reg, s1_cj_reg;
    logic [TAU_W-1:0]  s1_tau_reg;

    logic              s2_valid_reg;
    logic              s2_opposite_reg;
    logic [NUM_W-1:0]  s2_num_reg, s2_num_next;
    logic [QUAD_W-1:0] s2_quad_reg, s2_quad_next;
    logic [DS_W-1:0]   s2_ds_reg, s2_ds_next;
    logic [DS_W-1:0]   s2_cdiff_reg, s2_cdiff_next;
    logic [DATA_W-1:0] s2_ai_reg, s2_aj_reg, s2_ci_reg, s2_cj_reg;
    logic [TAU_W-1:0]  s2_tau_reg;

    logic  div_valid_reg [STAGES+1];
    div_t  div_reg       [STAGES+1];
    div_t  div_next      [STAGES+1];
    side_t side_reg      [STAGES+1];
    side_t side_next;

    logic          p1_valid_reg, p2_valid_reg, p3_valid_reg;
    side_t         p1_side_reg, p2_side_reg, p3_side_reg;
    logic [AW-1:0] p1_ai_reg, p1_aj_reg, p1_ai_next, p1_aj_next;
    logic [AW-1:0] p2_ai_reg, p2_aj_reg, p2_ai_next, p2_aj_next;
    logic [AW-1:0] p3_ai_reg, p3_aj_reg, p3_ai_next, p3_aj_next;

    logic              res_valid_reg;
    logic [DATA_W-1:0] alpha_i_new_reg, alpha_j_new_reg, alpha_i_new_next, alpha_j_new_next;
    logic [CHG_W-1:0]  change_i_reg, change_j_reg, change_i_next, change_j_next;

    logic [OCC_W-1:0] occupancy;

    assign advance   = !res_valid_reg || !res_stall;
    assign req_stall = !advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_positive_reg <= DATA_W'(65536);
            c_negative_reg <= DATA_W'(65536);
            tau_reg        <= TAU_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_C_POSITIVE: c_positive_reg <= cfg_data;
                CFG_C_NEGATIVE: c_negative_reg <= cfg_data;
                CFG_TAU:        tau_reg        <= cfg_data[TAU_W-1:0];
                default:        ;
            endcase
        end
    end

    // stage 1: capture request, pick bounds and tau
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_opposite_reg <= label_i_positive ^ label_j_positive;
            s1_gi_reg       <= grad_i;
            s1_gj_reg       <= grad_j;
            s1_kii_reg      <= kern_ii;
            s1_kjj_reg      <= kern_jj;
            s1_kij_reg      <= kern_ij;
            s1_ai_reg       <= alpha_i_old;
            s1_aj_reg       <= alpha_j_old;
            s1_ci_reg       <= label_i_positive ? c_positive_reg : c_negative_reg;
            s1_cj_reg       <= label_j_positive ? c_positive_reg : c_negative_reg;
            s1_tau_reg      <= (tau_reg == '0) ? TAU_W'(1) : tau_reg;
        end
    end

    // stage 2: numerator, quadratic coefficient, difference or sum
    always_comb
    begin
        logic signed [NUM_W-1:0]  gi_x, gj_x;
        logic signed [QUAD_W-1:0] kii_x, kjj_x, kij2_x;
        logic signed [DS_W-1:0]   ai_x, aj_x, ci_x, cj_x;
        gi_x   = $signed({{(NUM_W-DATA_W){s1_gi_reg[DATA_W-1]}}, s1_gi_reg});
        gj_x   = $signed({{(NUM_W-DATA_W){s1_gj_reg[DATA_W-1]}}, s1_gj_reg});
        kii_x  = $signed({{(QUAD_W-DATA_W){s1_kii_reg[DATA_W-1]}}, s1_kii_reg});
        kjj_x  = $signed({{(QUAD_W-DATA_W){s1_kjj_reg[DATA_W-1]}}, s1_kjj_reg});
        kij2_x = $signed({{(QUAD_W-DATA_W-1){s1_kij_reg[DATA_W-1]}}, s1_kij_reg, 1'b0});
        ai_x   = $signed({{(DS_W-DATA_W){1'b0}}, s1_ai_reg});
        aj_x   = $signed({{(DS_W-DATA_W){1'b0}}, s1_aj_reg});
        ci_x   = $signed({{(DS_W-DATA_W){1'b0}}, s1_ci_reg});
        cj_x   = $signed({{(DS_W-DATA_W){1'b0}}, s1_cj_reg});
        if (s1_opposite_reg)
        begin
            s2_num_next  = -gi_x - gj_x;
            s2_quad_next = kii_x + kjj_x + kij2_x;
            s2_ds_next   = ai_x - aj_x;
        end
        else
        begin
            s2_num_next  = gi_x - gj_x;
            s2_quad_next = kii_x + kjj_x - kij2_x;
            s2_ds_next   = ai_x + aj_x;
        end
        s2_cdiff_next = ci_x - cj_x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_opposite_reg <= s1_opposite_reg;
            s2_num_reg      <= s2_num_next;
            s2_quad_reg     <= s2_quad_next;
            s2_ds_reg       <= s2_ds_next;
            s2_cdiff_reg    <= s2_cdiff_next;
            s2_ai_reg       <= s1_ai_reg;
            s2_aj_reg       <= s1_aj_reg;
            s2_ci_reg       <= s1_ci_reg;
            s2_cj_reg       <= s1_cj_reg;
            s2_tau_reg      <= s1_tau_reg;
        end
    end

    // stage 3: magnitude, divisor select, clip conditions
    always_comb
    begin
        logic [NUM_W-1:0]       mag;
        logic                   quad_pos;
        logic signed [DS_W-1:0] ds_s, ci_s, cj_s;
        mag      = s2_num_reg[NUM_W-1] ? (NUM_W'(0) - s2_num_reg) : s2_num_reg;
        quad_pos = !s2_quad_reg[QUAD_W-1] && (s2_quad_reg != '0);
        ds_s     = $signed(s2_ds_reg);
        ci_s     = $signed({{(DS_W-DATA_W){1'b0}}, s2_ci_reg});
        cj_s     = $signed({{(DS_W-DATA_W){1'b0}}, s2_cj_reg});

        div_next[0].divisor = quad_pos ? s2_quad_reg[DIV_W-1:0]
                                       : {{(DIV_W-TAU_W){1'b0}}, s2_tau_reg};
        div_next[0].rem     = '0;
        div_next[0].dq      = {mag[MAG_W-1:0], {FRAC_BITS{1'b0}}};

        side_next.opposite    = s2_opposite_reg;
        side_next.num_neg     = s2_num_reg[NUM_W-1];
        side_next.ds          = s2_ds_reg;
        side_next.alpha_i_old = s2_ai_reg;
        side_next.alpha_j_old = s2_aj_reg;
        side_next.c_i         = s2_ci_reg;
        side_next.c_j         = s2_cj_reg;
        if (s2_opposite_reg)
        begin
            side_next.flag_a = ds_s > $signed(DS_W'(0));
            side_next.flag_b = ds_s > $signed(s2_cdiff_reg);
        end
        else
        begin
            side_next.flag_a = ds_s > ci_s;
            side_next.flag_b = ds_s > cj_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_valid_reg[0] <= 1'b0;
        else if (advance)
            div_valid_reg[0] <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_reg[0]  <= div_next[0];
            side_reg[0] <= side_next;
        end
    end

    // divider: one quotient bit per stage
    for (genvar k = 1; k <= STAGES; k++)
    begin : g_div
        always_comb
        begin
            logic [DIV_W:0] trial;
            logic [DIV_W:0] diff;
            logic           ge;
            trial = {div_reg[k-1].rem, div_reg[k-1].dq[DVD_W-1]};
            diff  = trial - {1'b0, div_reg[k-1].divisor};
            ge    = trial >= {1'b0, div_reg[k-1].divisor};
            div_next[k].divisor = div_reg[k-1].divisor;
            div_next[k].rem     = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            div_next[k].dq      = {div_reg[k-1].dq[DVD_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_valid_reg[k] <= 1'b0;
            else if (advance)
                div_valid_reg[k] <= div_valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                div_reg[k]  <= div_next[k];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // post 1: signed delta applied to both alphas
    always_comb
    begin
        logic signed [AW-1:0] q_x, delta, ai_x, aj_x;
        q_x   = $signed({{(AW-DVD_W){1'b0}}, div_reg[STAGES].dq});
        delta = side_reg[STAGES].num_neg ? -q_x : q_x;
        ai_x  = $signed({{(AW-DATA_W){1'b0}}, side_reg[STAGES].alpha_i_old});
        aj_x  = $signed({{(AW-DATA_W){1'b0}}, side_reg[STAGES].alpha_j_old});
        p1_ai_next = side_reg[STAGES].opposite ? ai_x + delta : ai_x - delta;
        p1_aj_next = aj_x + delta;
    end

    // post 2: clip against zero, or against C of i when the sum is kept
    always_comb
    begin
        logic signed [AW-1:0] ai, aj, dsx, cix;
        ai  = $signed(p1_ai_reg);
        aj  = $signed(p1_aj_reg);
        dsx = $signed({{(AW-DS_W){p1_side_reg.ds[DS_W-1]}}, p1_side_reg.ds});
        cix = $signed({{(AW-DATA_W){1'b0}}, p1_side_reg.c_i});
        p2_ai_next = ai;
        p2_aj_next = aj;
        if (p1_side_reg.opposite)
        begin
            if (p1_side_reg.flag_a)
            begin
                if (aj < 0)
                begin
                    p2_aj_next = '0;
                    p2_ai_next = dsx;
                end
            end
            else if (ai < 0)
            begin
                p2_ai_next = '0;
                p2_aj_next = -dsx;
            end
        end
        else
        begin
            if (p1_side_reg.flag_a)
            begin
                if (ai > cix)
                begin
                    p2_ai_next = cix;
                    p2_aj_next = dsx - cix;
                end
            end
            else if (aj < 0)
            begin
                p2_aj_next = '0;
                p2_ai_next = dsx;
            end
        end
    end

    // post 3: clip against the upper bounds, or against zero for alpha i when the sum is kept
    always_comb
    begin
        logic signed [AW-1:0] ai, aj, dsx, cix, cjx;
        ai  = $signed(p2_ai_reg);
        aj  = $signed(p2_aj_reg);
        dsx = $signed({{(AW-DS_W){p2_side_reg.ds[DS_W-1]}}, p2_side_reg.ds});
        cix = $signed({{(AW-DATA_W){1'b0}}, p2_side_reg.c_i});
        cjx = $signed({{(AW-DATA_W){1'b0}}, p2_side_reg.c_j});
        p3_ai_next = ai;
        p3_aj_next = aj;
        if (p2_side_reg.opposite)
        begin
            if (p2_side_reg.flag_b)
            begin
                if (ai > cix)
                begin
                    p3_ai_next = cix;
                    p3_aj_next = cix - dsx;
                end
            end
            else if (aj > cjx)
            begin
                p3_aj_next = cjx;
                p3_ai_next = cjx + dsx;
            end
        end
        else
        begin
            if (p2_side_reg.flag_b)
            begin
                if (aj > cjx)
                begin
                    p3_aj_next = cjx;
                    p3_ai_next = dsx - cjx;
                end
            end
            else if (ai < 0)
            begin
                p3_ai_next = '0;
                p3_aj_next = dsx;
            end
        end
    end

    // post 4: saturate and form changes
    always_comb
    begin
        if (p3_ai_reg[AW-1])
            alpha_i_new_next = '0;
        else if (p3_ai_reg[AW-2:DATA_W] != '0)
            alpha_i_new_next = '1;
        else
            alpha_i_new_next = p3_ai_reg[DATA_W-1:0];
        if (p3_aj_reg[AW-1])
            alpha_j_new_next = '0;
        else if (p3_aj_reg[AW-2:DATA_W] != '0)
            alpha_j_new_next = '1;
        else
            alpha_j_new_next = p3_aj_reg[DATA_W-1:0];
        change_i_next = {1'b0, alpha_i_new_next} - {1'b0, p3_side_reg.alpha_i_old};
        change_j_next = {1'b0, alpha_j_new_next} - {1'b0, p3_side_reg.alpha_j_old};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_valid_reg  <= div_valid_reg[STAGES];
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            res_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_ai_reg       <= p1_ai_next;
            p1_aj_reg       <= p1_aj_next;
            p1_side_reg     <= side_reg[STAGES];
            p2_ai_reg       <= p2_ai_next;
            p2_aj_reg       <= p2_aj_next;
            p2_side_reg     <= p1_side_reg;
            p3_ai_reg       <= p3_ai_next;
            p3_aj_reg       <= p3_aj_next;
            p3_side_reg     <= p2_side_reg;
            alpha_i_new_reg <= alpha_i_new_next;
            alpha_j_new_reg <= alpha_j_new_next;
            change_i_reg    <= change_i_next;
            change_j_reg    <= change_j_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign alpha_i_new = alpha_i_new_reg;
    assign alpha_j_new = alpha_j_new_reg;
    assign change_i    = change_i_reg;
    assign change_j    = change_j_reg;

    always_comb
    begin
        occupancy[0] = s1_valid_reg;
        occupancy[1] = s2_valid_reg;
        for (int k = 0; k <= STAGES; k++)
            occupancy[k+2] = div_valid_reg[k];
        occupancy[STAGES+3] = p1_valid_reg;
        occupancy[STAGES+4] = p2_valid_reg;
        occupancy[STAGES+5] = p3_valid_reg;
        occupancy[STAGES+6] = res_valid_reg;
    end

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> s1_valid_reg)
        else $error("accepted request did not enter stage 1");

    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(occupancy))
        else $error("pipeline occupancy moved during a stall");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[0] |-> (div_reg[0].divisor != '0))
        else $error("divider entered with zero divisor");

    a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[STAGES] |-> (div_reg[STAGES].rem < div_reg[STAGES].divisor))
        else $error("final remainder not below divisor");

endmodule

`default_nettype wire

[dv/smo_pair_alpha_update_tb.sv]
// Self-checking testbench for the SMO pair alpha update pipeline.
`timescale 1ns / 100ps

module smo_pair_alpha_update_tb;
    import smo_pau_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int PIPE_LATENCY = 56;
    localparam int GAP_PERCENT  = 31;

    typedef struct {
        logic              label_i_positive;
        logic              label_j_positive;
        logic signed [31:0] grad_i;
        logic signed [31:0] grad_j;
        logic signed [31:0] kern_ii;
        logic signed [31:0] kern_jj;
        logic signed [31:0] kern_ij;
        logic [31:0]       alpha_i_old;
        logic [31:0]       alpha_j_old;
    } pair_req_t;

    typedef struct {
        logic [31:0] alpha_i_new;
        logic [31:0] alpha_j_new;
        logic [32:0] change_i;
        logic [32:0] change_j;
    } alpha_update_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic                 label_i_positive = 1'b0;
    logic                 label_j_positive = 1'b0;
    logic [DATA_W-1:0]    grad_i = '0;
    logic [DATA_W-1:0]    grad_j = '0;
    logic [DATA_W-1:0]    kern_ii = '0;
    logic [DATA_W-1:0]    kern_jj = '0;
    logic [DATA_W-1:0]    kern_ij = '0;
    logic [DATA_W-1:0]    alpha_i_old = '0;
    logic [DATA_W-1:0]    alpha_j_old = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic [DATA_W-1:0]    alpha_i_new;
    logic [DATA_W-1:0]    alpha_j_new;
    logic [CHG_W-1:0]     change_i;
    logic [CHG_W-1:0]     change_j;

    logic [31:0]      bound_pos = 32'h0001_0000;
    logic [31:0]      bound_neg = 32'h0001_0000;
    logic [TAU_W-1:0] tau_reg = 17'd1;

    logic send_gaps = 1'b0;
    logic recv_gaps = 1'b0;
    int   fail_count = 0;

    pair_req_t     pending_pairs[$];
    alpha_update_t expected_updates[$];
    pair_req_t     driven_pair;

    smo_pair_alpha_update i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp_alpha(longint v);
        if (v < 0)
            return 64'sd0;
        if (v > 64'sh0_FFFF_FFFF)
            return 64'sh0_FFFF_FFFF;
        return v;
    endfunction

    function automatic alpha_update_t predict_pair(pair_req_t p);
        longint gi, gj, qii, qjj, qij, ai_old, aj_old, ci, cj, tau_v;
        longint span, quad, num, shift, ai, aj, ni, nj, di, dj;
        alpha_update_t u;
        gi = longint'(p.grad_i);
        gj = longint'(p.grad_j);
        qii = longint'(p.kern_ii);
        qjj = longint'(p.kern_jj);
        qij = longint'(p.kern_ij);
        ai_old = longint'(p.alpha_i_old);
        aj_old = longint'(p.alpha_j_old);
        ci = p.label_i_positive ? longint'(bound_pos) : longint'(bound_neg);
        cj = p.label_j_positive ? longint'(bound_pos) : longint'(bound_neg);
        tau_v = (tau_reg == '0) ? 64'sd1 : longint'(tau_reg);
        if (p.label_i_positive != p.label_j_positive)
        begin
            span = ai_old - aj_old;
            quad = qii + qjj + 2 * qij;
            num = -gi - gj;
        end
        else
        begin
            span = ai_old + aj_old;
            quad = qii + qjj - 2 * qij;
            num = gi - gj;
        end
        if (quad <= 0)
            quad = tau_v;
        shift = (num * 65536) / quad;
        if (p.label_i_positive != p.label_j_positive)
        begin
            ai = ai_old + shift;
            aj = aj_old + shift;
            if (span > 0)
            begin
                if (aj < 0)
                begin
                    aj = 0;
                    ai = span;
                end
            end
            else if (ai < 0)
            begin
                ai = 0;
                aj = -span;
            end
            if (span > ci - cj)
            begin
                if (ai > ci)
                begin
                    ai = ci;
                    aj = ci - span;
                end
            end
            else if (aj > cj)
            begin
                aj = cj;
                ai = cj + span;
            end
        end
        else
        begin
            ai = ai_old - shift;
            aj = aj_old + shift;
            if (span > ci)
            begin
                if (ai > ci)
                begin
                    ai = ci;
                    aj = span - ci;
                end
            end
            else if (aj < 0)
            begin
                aj = 0;
                ai = span;
            end
            if (span > cj)
            begin
                if (aj > cj)
                begin
                    aj = cj;
                    ai = span - cj;
                end
            end
            else if (ai < 0)
            begin
                ai = 0;
                aj = span;
            end
        end
        ni = clamp_alpha(ai);
        nj = clamp_alpha(aj);
        di = ni - ai_old;
        dj = nj - aj_old;
        u.alpha_i_new = ni[31:0];
        u.alpha_j_new = nj[31:0];
        u.change_i = di[32:0];
        u.change_j = dj[32:0];
        return u;
    endfunction

    function automatic pair_req_t random_pair();
        pair_req_t p;
        p.label_i_positive = 1'($urandom_range(1));
        p.label_j_positive = 1'($urandom_range(1));
        if ($urandom_range(99) < 30)
        begin
            p.grad_i = $urandom;
            p.grad_j = $urandom;
            p.kern_ii = $urandom;
            p.kern_jj = $urandom;
            p.kern_ij = $urandom;
            p.alpha_i_old = $urandom;
            p.alpha_j_old = $urandom;
        end
        else
        begin
            p.grad_i = $urandom_range(32'h0010_0000) - 32'h0008_0000;
            p.grad_j = $urandom_range(32'h0010_0000) - 32'h0008_0000;
            p.kern_ii = $urandom_range(32'h0004_0000);
            p.kern_jj = $urandom_range(32'h0004_0000);
            p.kern_ij = $urandom_range(32'h0004_0000) - 32'h0002_0000;
            p.alpha_i_old = $urandom_range(p.label_i_positive ? bound_pos : bound_neg);
            p.alpha_j_old = $urandom_range(p.label_j_positive ? bound_pos : bound_neg);
            // pin to the box corners now and then
            if ($urandom_range(9) == 0)
                p.alpha_i_old = $urandom_range(1) ? 32'h0 :
                                (p.label_i_positive ? bound_pos : bound_neg);
            if ($urandom_range(9) == 0)
                p.alpha_j_old = $urandom_range(1) ? 32'h0 :
                                (p.label_j_positive ? bound_pos : bound_neg);
        end
        return p;
    endfunction

    task automatic queue_pair(input int li, input int lj,
                              input logic [31:0] gi, input logic [31:0] gj,
                              input logic [31:0] kii, input logic [31:0] kjj,
                              input logic [31:0] kij,
                              input logic [31:0] ai, input logic [31:0] aj);
        pair_req_t p;
        p.label_i_positive = li[0];
        p.label_j_positive = lj[0];
        p.grad_i = gi;
        p.grad_j = gj;
        p.kern_ii = kii;
        p.kern_jj = kjj;
        p.kern_ij = kij;
        p.alpha_i_old = ai;
        p.alpha_j_old = aj;
        pending_pairs.push_back(p);
    endtask

    task automatic queue_random(input int count);
        repeat (count)
            pending_pairs.push_back(random_pair());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_C_POSITIVE: bound_pos = value;
            CFG_C_NEGATIVE: bound_neg = value;
            CFG_TAU:        tau_reg = value[TAU_W-1:0];
            default:        ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_pairs.size() != 0 || req_valid || expected_updates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(input string field, input logic [32:0] want,
                               input logic [32:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pair_req_t next;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_updates.push_back(predict_pair(driven_pair));
            if (!req_valid || !req_stall)
            begin
                if (pending_pairs.size() != 0 &&
                    !(send_gaps && $urandom_range(99) < GAP_PERCENT))
                begin
                    next = pending_pairs.pop_front();
                    driven_pair <= next;
                    label_i_positive <= next.label_i_positive;
                    label_j_positive <= next.label_j_positive;
                    grad_i <= next.grad_i;
                    grad_j <= next.grad_j;
                    kern_ii <= next.kern_ii;
                    kern_jj <= next.kern_jj;
                    kern_ij <= next.kern_ij;
                    alpha_i_old <= next.alpha_i_old;
                    alpha_j_old <= next.alpha_j_old;
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        alpha_update_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_updates.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_updates.pop_front();
                    check_field("alpha_i_new", {1'b0, want.alpha_i_new}, {1'b0, alpha_i_new});
                    check_field("alpha_j_new", {1'b0, want.alpha_j_new}, {1'b0, alpha_j_new});
                    check_field("change_i", want.change_i, change_i);
                    check_field("change_j", want.change_j, change_j);
                end
            end
            res_stall <= recv_gaps && ($urandom_range(99) < GAP_PERCENT);
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        send_gaps <= 1'b1;
        recv_gaps <= 1'b1;
        @(posedge clk);

        // box [0, 1.0], tau 1
        queue_pair(1, 0, 32'hFFFF_8000, 32'hFFFF_C000, 32'h0001_0000, 32'h0001_0000,
                   32'h0000_4000, 32'h0000_4000, 32'h0000_8000);
        queue_pair(0, 1, 32'h0000_8000, 32'h0000_4000, 32'h0002_0000, 32'h0001_0000,
                   32'hFFFF_C000, 32'h0000_C000, 32'h0000_2000);
        queue_pair(1, 1, 32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000, 32'h0001_0000,
                   32'h0000_8000, 32'h0000_8000, 32'h0000_4000);
        queue_pair(0, 0, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000, 32'h0003_0000,
                   32'h0000_4000, 32'h0000_1000, 32'h0000_F000);
        queue_pair(1, 0, 32'h0000_0100, 32'h0000_0200, 32'h0001_0000, 32'h0001_0000,
                   32'hFFFF_0000, 32'h0000_8000, 32'h0000_8000);
        queue_pair(1, 1, 32'h0000_0010, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                   32'h0001_0000, 32'h0000_4000, 32'h0000_4000);
        queue_pair(0, 1, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000,
                   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_pair(1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_pair(1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_pair(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_pair(0, 0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        queue_pair(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_pair(1, 0, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000,
                   32'h0000_0000, 32'h0005_0000, 32'h0003_0000);
        queue_pair(0, 0, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                   32'h0000_0000, 32'h0002_0000, 32'h0004_0000);
        queue_pair(1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                   32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        queue_pair(0, 1, 32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0001, 32'h0000_0001,
                   32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
        queue_pair(1, 0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'h3333_3333, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_pair(0, 1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'hCCCC_CCCC, 32'hAAAA_AAAA, 32'h5555_5555);
        drain();

        write_reg(CFG_C_POSITIVE, 32'h0003_0000);
        write_reg(CFG_C_NEGATIVE, 32'h0000_8000);
        write_reg(CFG_TAU, 32'h0001_0000);
        queue_random(350);
        drain();

        // hold both sides busy for a whole phase
        send_gaps <= 1'b0;
        recv_gaps <= 1'b0;
        write_reg(CFG_C_POSITIVE, 32'h0000_0000);
        write_reg(CFG_C_NEGATIVE, 32'hFFFF_FFFF);
        write_reg(CFG_TAU, 32'h0000_0000);
        queue_random(250);
        drain();

        send_gaps <= 1'b1;
        recv_gaps <= 1'b1;
        write_reg(CFG_C_POSITIVE, 32'hFFFF_FFFF);
        write_reg(CFG_C_NEGATIVE, 32'h0000_0000);
        write_reg(CFG_TAU, 32'hFFFF_FFFF);
        queue_random(250);
        drain();

        write_reg(CFG_C_POSITIVE, $urandom_range(32'h000A_0000));
        write_reg(CFG_C_NEGATIVE, $urandom_range(32'h000A_0000));
        write_reg(CFG_TAU, $urandom_range(32'h0001_0000, 1));
        queue_random(300);
        drain();

        write_reg(CFG_UNUSED, $urandom);
        write_reg(CFG_C_POSITIVE, 32'h0002_0000);
        write_reg(CFG_C_NEGATIVE, 32'h0002_0000);
        write_reg(CFG_TAU, 32'h0000_0001);
        queue_random(300);
        drain();

        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
